[rtl/core/sha256_pkg.sv]
// sha256_pkg: shared constants, round constants and helper functions
// for the byte-serial hasher; depends on nothing
`default_nettype none
package sha256_pkg;
    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds = 64;
    localparam int unsigned DigestWords = 8;
    localparam int unsigned LenBytesOffset = 56;
    localparam logic [7:0] PadByte = 8'h80;

    localparam logic [31:0] INIT_H [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    typedef logic [31:0] word_t;

    function automatic word_t ror32(input word_t x, input int unsigned n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

    // control from the sequencer to the round unit
    typedef struct packed {
        logic start;
        logic load_w;
        logic round;
        logic fold;
    } rnd_ctl_t;
endpackage
`default_nettype wire

[rtl/core/sha256_if.sv]
// sha256_if: valid/ready channel carrying one payload word
// depends on nothing
`default_nettype none
interface sha256_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/core/sha256_round.sv]
// sha256_round: shared compression round unit with message schedule window
// and chaining words; depends on sha256_pkg
`default_nettype none
module sha256_round (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sha256_pkg::rnd_ctl_t ctl,
    input  wire logic [5:0]         round_idx,
    input  wire logic [31:0]        w_in,
    input  wire logic               init,
    input  wire logic [2:0]         rd_idx,
    output logic [31:0]             rd_word
);
    logic [31:0] h_reg [0:7];
    logic [31:0] v_reg [0:7];
    logic [31:0] w_reg [0:15];
    logic [31:0] wt, s0, s1, wn, t1, t2, big0, big1, ch, maj;

    always_comb
    begin
        s0 = sha256_pkg::ror32(w_reg[1], 7) ^ sha256_pkg::ror32(w_reg[1], 18)
            ^ (w_reg[1] >> 3);
        s1 = sha256_pkg::ror32(w_reg[14], 17) ^ sha256_pkg::ror32(w_reg[14], 19)
            ^ (w_reg[14] >> 10);
        wn = w_reg[0] + s0 + w_reg[9] + s1;
        wt = w_reg[0];
        big1 = sha256_pkg::ror32(v_reg[4], 6) ^ sha256_pkg::ror32(v_reg[4], 11)
            ^ sha256_pkg::ror32(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + big1 + ch + sha256_pkg::ROUND_K[round_idx] + wt;
        big0 = sha256_pkg::ror32(v_reg[0], 2) ^ sha256_pkg::ror32(v_reg[0], 13)
            ^ sha256_pkg::ror32(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = big0 + maj;
    end

    assign rd_word = h_reg[rd_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha256_pkg::INIT_H[i];
            end
        end
        else if (init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha256_pkg::INIT_H[i];
            end
        end
        else if (ctl.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_w)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_in;
        end
        else if (ctl.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= wn;
        end
        if (ctl.start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (ctl.round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end
endmodule
`default_nettype wire

[rtl/core/sha256_message_hasher.sv]
// sha256_message_hasher: top level, byte buffer, padding sequencer, output
// depends on sha256_pkg, sha256_if, sha256_round
//
// One byte a word; a byte that does not fill a block is written to the buffer and
// the hasher stays ready. A byte that fills a block is followed by 16 word loads,
// 64 rounds of the single round unit and a fold. Closing a message writes the
// rest of the block (marker, zeros, length) one byte a cycle, then compresses
// it the same way; when the marker lands in the last eight bytes a second
// padded block of 64 byte writes and its compression follows. Eight digest
// words then leave, one per cycle that the sink is ready. While a block is
// compressed the one shared round unit keeps the hasher from taking bytes.
`default_nettype none
module sha256_message_hasher (
    input wire logic clk,
    input wire logic rst_n,
    sha256_if.sink   in_ch,
    sha256_if.source out_ch
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_FOLD = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [6:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic        closing_reg, closing_next;
    logic        lenblk_reg, lenblk_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic        init;
    logic [31:0] buf_mem [0:15];
    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [7:0]  wr_data;
    logic [31:0] w_in, rd_word;
    sha256_pkg::rnd_ctl_t ctl;

    logic [7:0]  in_byte;
    logic        in_present, in_end;
    assign in_byte = in_ch.payload.data_byte;
    assign in_present = in_ch.payload.byte_present;
    assign in_end = in_ch.payload.end_of_message;

    assign in_ch.ready = (state_reg == ST_IDLE);
    logic acc;
    assign acc = in_ch.valid && in_ch.ready;

    // big-endian byte lanes within each schedule word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_mem[wr_addr[5:2]][{~wr_addr[1:0], 3'd0} +: 8] <= wr_data;
        end
    end

    assign w_in = buf_mem[cnt_reg[3:0]];

    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg;
        bits_next = bits_reg;
        closing_next = closing_reg;
        lenblk_next = lenblk_reg;
        cnt_next = cnt_reg;
        oidx_next = oidx_reg;
        wr_en = 1'b0;
        wr_addr = fill_reg[5:0];
        wr_data = in_byte;
        init = 1'b0;
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    closing_next = in_end;
                    lenblk_next = 1'b0;
                    if (in_present)
                    begin
                        wr_en = 1'b1;
                        fill_next = fill_reg + 7'd1;
                        bits_next = bits_reg + 64'd8;
                        if (fill_reg == 7'd63)
                        begin
                            state_next = ST_LOAD;
                            cnt_next = '0;
                        end
                        else if (in_end)
                        begin
                            state_next = ST_PAD;
                        end
                    end
                    else if (in_end)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                // first pad step writes the marker byte, later steps zero or length
                wr_en = 1'b1;
                fill_next = fill_reg + 7'd1;
                if (!lenblk_reg)
                begin
                    wr_data = sha256_pkg::PadByte;
                    lenblk_next = 1'b1;
                end
                else if (fill_reg >= 7'(sha256_pkg::LenBytesOffset) && !closing_reg)
                begin
                    wr_data = 8'(bits_reg >> (7'd63 - {fill_reg[2:0], 3'd7}));
                end
                else
                begin
                    wr_data = 8'd0;
                end
                if (fill_reg == 7'd63)
                begin
                    state_next = ST_LOAD;
                    cnt_next = '0;
                end
            end
            ST_LOAD:
            begin
                ctl.load_w = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd15)
                begin
                    ctl.start = 1'b1;
                    state_next = ST_RND;
                    cnt_next = '0;
                end
            end
            ST_RND:
            begin
                ctl.round = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                ctl.fold = 1'b1;
                fill_next = '0;
                if (!lenblk_reg && closing_reg)
                begin
                    state_next = ST_PAD;
                end
                else if (lenblk_reg && closing_reg)
                begin
                    // block held marker but no room for length
                    closing_next = 1'b0;
                    state_next = ST_PAD;
                end
                else if (lenblk_reg)
                begin
                    state_next = ST_OUT;
                    oidx_next = '0;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        init = 1'b1;
                        state_next = ST_IDLE;
                        bits_next = '0;
                        fill_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // after the marker lands, closing_reg is set only when the length no longer
    // fits in this block; the fold then clears it to force one more padded block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg <= '0;
            bits_reg <= '0;
            closing_reg <= 1'b0;
            lenblk_reg <= 1'b0;
            cnt_reg <= '0;
            oidx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            bits_reg <= bits_next;
            lenblk_reg <= lenblk_next;
            cnt_reg <= cnt_next;
            oidx_reg <= oidx_next;
            // marker write decides whether the length still fits in this block
            if (state_reg == ST_PAD && !lenblk_reg)
            begin
                closing_reg <= (fill_reg > 7'(sha256_pkg::LenBytesOffset - 1));
            end
            else if (state_reg == ST_FOLD && lenblk_reg && !closing_reg)
            begin
                closing_reg <= 1'b0;
            end
            else
            begin
                closing_reg <= closing_next;
            end
        end
    end

    sha256_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .round_idx (cnt_reg),
        .w_in      (w_in),
        .init      (init),
        .rd_idx    (oidx_reg),
        .rd_word   (rd_word)
    );

    assign out_ch.valid = (state_reg == ST_OUT);
    assign out_ch.payload.digest_word = rd_word;
    assign out_ch.payload.word_index = oidx_reg;
    assign out_ch.payload.last_word = (oidx_reg == 3'd7);

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ch.ready)
        else $error("input taken while busy");
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (fill_reg < 7'd64))
        else $error("fill out of range");
    a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && oidx_reg != 3'd7) |=> (state_reg == ST_OUT))
        else $error("digest cut short");
    a_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RND && cnt_reg == 6'd63) |=> (state_reg == ST_FOLD))
        else $error("round count slip");
endmodule
`default_nettype wire
